// File: rtl/ppm_lh_pkg.sv
// ----------------------------------------------------------------------------
// ppm_lh_pkg
// Shared types and constants of the PPM luma histogram block.
// ----------------------------------------------------------------------------
package ppm_lh_pkg;

  // Default sizing of the block.
  localparam int MAX_DIM_DEF   = 65535;
  localparam int BIN_CNT_W_DEF = 32;
  localparam int OUT_CNT_W     = 32;
  localparam int NUM_BINS      = 5;

  // Luma weights in 16-bit fixed point; they sum to 65536.
  localparam logic [15:0] W_RED      = 16'd13933;
  localparam logic [15:0] W_GREEN    = 16'd46871;
  localparam logic [15:0] W_BLUE     = 16'd4732;
  localparam logic [23:0] ROUND_HALF = 24'd32768;

  // Upper bounds of the lower four bins.
  localparam logic [7:0] LIM_DARK = 8'd50;
  localparam logic [7:0] LIM_LOW  = 8'd101;
  localparam logic [7:0] LIM_MID  = 8'd152;
  localparam logic [7:0] LIM_HIGH = 8'd203;

  // Bin indexes.
  localparam int BIN_DARK   = 0;
  localparam int BIN_LOW    = 1;
  localparam int BIN_MID    = 2;
  localparam int BIN_HIGH   = 3;
  localparam int BIN_BRIGHT = 4;

  // Colour channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Header characters.
  localparam logic [7:0] CHR_P  = 8'h50;
  localparam logic [7:0] CHR_6  = 8'h36;
  localparam logic [7:0] CHR_2  = 8'h32;
  localparam logic [7:0] CHR_5  = 8'h35;
  localparam logic [7:0] CHR_0  = 8'h30;
  localparam logic [7:0] CHR_9  = 8'h39;
  localparam logic [7:0] CHR_LF = 8'h0A;

  // Result status codes.
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_ERR  = 1'b1;

  // Per-beat control from the header parser to the bin counter.
  typedef struct packed {
    logic       pix;   // beat is a pixel colour byte
    logic [1:0] chan;  // colour channel of that byte
    logic       emit;  // beat finishes a result and clears the state
    logic       err;   // result is a header error
  } ctl_t;

endpackage

// File: rtl/ppm_lh_if.sv
// ----------------------------------------------------------------------------
// ppm_lh_in_if / ppm_lh_res_if
// Valid/ready channels for the input bytes and the histogram results.
// ----------------------------------------------------------------------------
interface ppm_lh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppm_lh_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] bin_dark;
  logic [31:0] bin_low;
  logic [31:0] bin_mid;
  logic [31:0] bin_high;
  logic [31:0] bin_bright;

  modport source (output valid, output status, output bin_dark, output bin_low,
                  output bin_mid, output bin_high, output bin_bright, input ready);
  modport sink   (input valid, input status, input bin_dark, input bin_low,
                  input bin_mid, input bin_high, input bin_bright, output ready);
endinterface

// File: rtl/ppm_lh_hdr.sv
// ----------------------------------------------------------------------------
// ppm_lh_hdr
// Header parser and pixel sequencer: checks the magic, size and maxval
// fields, keeps the pixel count and the colour channel of each byte.
// ----------------------------------------------------------------------------
module ppm_lh_hdr #(
  parameter int MaxDim = ppm_lh_pkg::MAX_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output ppm_lh_pkg::ctl_t  ctl_o
);

  localparam int DimW = $clog2(MaxDim + 1);
  localparam int AccW = DimW + 4;
  localparam int PixW = 2 * DimW;

  localparam logic [3:0] PH_MAGIC_P = 4'd0;
  localparam logic [3:0] PH_MAGIC_6 = 4'd1;
  localparam logic [3:0] PH_SEP1    = 4'd2;
  localparam logic [3:0] PH_WIDTH   = 4'd3;
  localparam logic [3:0] PH_HEIGHT  = 4'd4;
  localparam logic [3:0] PH_HUE_2   = 4'd5;
  localparam logic [3:0] PH_HUE_5A  = 4'd6;
  localparam logic [3:0] PH_HUE_5B  = 4'd7;
  localparam logic [3:0] PH_SEP2    = 4'd8;
  localparam logic [3:0] PH_PIXELS  = 4'd9;

  logic [3:0]      phase_q, phase_d;
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic [PixW-1:0] pix_left_q, pix_left_d;
  logic [1:0]      chan_q, chan_d;

  logic            is_digit;
  logic [DimW-1:0] size_cur;
  logic [AccW-1:0] size_next;
  logic            size_ok;
  logic            emit, err;

  assign is_digit  = (byte_i >= ppm_lh_pkg::CHR_0) && (byte_i <= ppm_lh_pkg::CHR_9);
  assign size_cur  = (phase_q == PH_WIDTH) ? width_q : height_q;
  assign size_next = {size_cur, 3'b000} + {3'b000, size_cur, 1'b0}
                   + AccW'(byte_i - ppm_lh_pkg::CHR_0);
  assign size_ok   = is_digit && (size_next <= AccW'(MaxDim));

  always_comb begin
    phase_d    = phase_q;
    width_d    = width_q;
    height_d   = height_q;
    pix_left_d = pix_left_q;
    chan_d     = chan_q;
    emit       = 1'b0;
    err        = 1'b0;
    unique case (phase_q)
      PH_MAGIC_P: begin
        if (byte_i != ppm_lh_pkg::CHR_P) err = 1'b1;
        else phase_d = PH_MAGIC_6;
      end
      PH_MAGIC_6: begin
        if (byte_i != ppm_lh_pkg::CHR_6) err = 1'b1;
        else phase_d = PH_SEP1;
      end
      PH_SEP1: phase_d = PH_WIDTH;
      PH_WIDTH, PH_HEIGHT: begin
        if (byte_i == ppm_lh_pkg::CHR_LF) begin
          phase_d = (phase_q == PH_WIDTH) ? PH_HEIGHT : PH_HUE_2;
        end else if (!size_ok) begin
          err = 1'b1;
        end else if (phase_q == PH_WIDTH) begin
          width_d = size_next[DimW-1:0];
        end else begin
          height_d = size_next[DimW-1:0];
        end
      end
      PH_HUE_2: begin
        if (byte_i != ppm_lh_pkg::CHR_2) err = 1'b1;
        else phase_d = PH_HUE_5A;
      end
      PH_HUE_5A: begin
        if (byte_i != ppm_lh_pkg::CHR_5) err = 1'b1;
        else phase_d = PH_HUE_5B;
      end
      PH_HUE_5B: begin
        if (byte_i != ppm_lh_pkg::CHR_5) err = 1'b1;
        else phase_d = PH_SEP2;
      end
      PH_SEP2: begin
        pix_left_d = PixW'(width_q * height_q);
        chan_d     = ppm_lh_pkg::CH_RED;
        if ((width_q == '0) || (height_q == '0)) emit = 1'b1;
        else phase_d = PH_PIXELS;
      end
      PH_PIXELS: begin
        unique case (chan_q)
          ppm_lh_pkg::CH_RED:   chan_d = ppm_lh_pkg::CH_GREEN;
          ppm_lh_pkg::CH_GREEN: chan_d = ppm_lh_pkg::CH_BLUE;
          default: begin
            chan_d     = ppm_lh_pkg::CH_RED;
            pix_left_d = pix_left_q - PixW'(1);
            if (pix_left_q == PixW'(1)) emit = 1'b1;
          end
        endcase
      end
      default: begin
        phase_d    = PH_MAGIC_P;
        width_d    = '0;
        height_d   = '0;
        pix_left_d = '0;
        chan_d     = ppm_lh_pkg::CH_RED;
      end
    endcase
    if (emit || err) begin
      phase_d    = PH_MAGIC_P;
      width_d    = '0;
      height_d   = '0;
      pix_left_d = '0;
      chan_d     = ppm_lh_pkg::CH_RED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC_P;
      width_q    <= '0;
      height_q   <= '0;
      pix_left_q <= '0;
      chan_q     <= ppm_lh_pkg::CH_RED;
    end else if (step_i) begin
      phase_q    <= phase_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pix_left_q <= pix_left_d;
      chan_q     <= chan_d;
    end
  end

  assign ctl_o.pix  = (phase_q == PH_PIXELS);
  assign ctl_o.chan = chan_q;
  assign ctl_o.emit = emit || err;
  assign ctl_o.err  = err;

endmodule

// File: rtl/ppm_lh_bins.sv
// ----------------------------------------------------------------------------
// ppm_lh_bins
// Luma accumulator and the five saturating bin counters.
// ----------------------------------------------------------------------------
module ppm_lh_bins #(
  parameter int BinCntW = ppm_lh_pkg::BIN_CNT_W_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          step_i,
  input  logic [7:0]                                    byte_i,
  input  ppm_lh_pkg::ctl_t                              ctl_i,
  output logic [ppm_lh_pkg::NUM_BINS-1:0][BinCntW-1:0]  counts_o
);

  localparam int NumBins = ppm_lh_pkg::NUM_BINS;

  logic [23:0]                     partial_q, partial_d;
  logic [NumBins-1:0][BinCntW-1:0] cnt_q, cnt_d;
  logic [15:0]                     weight;
  logic [23:0]                     product, base, luma_sum;
  logic [7:0]                      luma;
  logic [NumBins-1:0]              hit;

  always_comb begin
    unique case (ctl_i.chan)
      ppm_lh_pkg::CH_RED:   weight = ppm_lh_pkg::W_RED;
      ppm_lh_pkg::CH_GREEN: weight = ppm_lh_pkg::W_GREEN;
      default:              weight = ppm_lh_pkg::W_BLUE;
    endcase
  end

  // One constant-weight product per colour byte; blue also adds the rounding.
  assign product  = 24'(weight * byte_i);
  assign base     = (ctl_i.chan == ppm_lh_pkg::CH_RED) ? '0 : partial_q;
  assign luma_sum = base + product
                  + ((ctl_i.chan == ppm_lh_pkg::CH_BLUE) ? ppm_lh_pkg::ROUND_HALF : '0);
  assign luma     = luma_sum[23:16];

  always_comb begin
    hit = '0;
    if (ctl_i.pix && (ctl_i.chan == ppm_lh_pkg::CH_BLUE)) begin
      priority if (luma <= ppm_lh_pkg::LIM_DARK) hit[ppm_lh_pkg::BIN_DARK] = 1'b1;
      else if (luma <= ppm_lh_pkg::LIM_LOW)      hit[ppm_lh_pkg::BIN_LOW] = 1'b1;
      else if (luma <= ppm_lh_pkg::LIM_MID)      hit[ppm_lh_pkg::BIN_MID] = 1'b1;
      else if (luma <= ppm_lh_pkg::LIM_HIGH)     hit[ppm_lh_pkg::BIN_HIGH] = 1'b1;
      else                                       hit[ppm_lh_pkg::BIN_BRIGHT] = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < NumBins; i++) begin
      cnt_d[i] = cnt_q[i];
      if (hit[i] && (cnt_q[i] != '1)) cnt_d[i] = cnt_q[i] + BinCntW'(1);
    end
  end

  assign partial_d = (ctl_i.pix && (ctl_i.chan != ppm_lh_pkg::CH_BLUE)) ? luma_sum : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      partial_q <= ctl_i.emit ? '0 : partial_d;
      cnt_q     <= ctl_i.emit ? '0 : cnt_d;
    end
  end

  // Counts including this beat's pixel, for the result register.
  assign counts_o = cnt_d;

endmodule

// File: rtl/ppm_luma_histogram.sv
// ----------------------------------------------------------------------------
// ppm_luma_histogram
// Parses a binary PPM byte stream and returns a five-bin luma histogram.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                  Beat
//   in_i     in   data_byte[7:0]                           one file byte
//   res_o    out  status, bin_dark/low/mid/high/bright     one result
//
// Every byte is taken into an input register and processed from there, so a
// byte is accepted every cycle while the result register is free or drains;
// the byte that ends the file or the header error loads the result register.
// The processing stage is a single constant-weight 16x8 multiply, an add and
// the bin compare; the width by height product is formed in the same stage.
// Reset clears the parser, the accumulator, the counters and both valid flags.
// While a result waits to be taken, one more byte is still taken into the
// input register and then the input is held off until the result drains.
// ----------------------------------------------------------------------------
module ppm_luma_histogram #(
  parameter int MaxDim  = ppm_lh_pkg::MAX_DIM_DEF,
  parameter int BinCntW = ppm_lh_pkg::BIN_CNT_W_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppm_lh_in_if.sink           in_i,
  ppm_lh_res_if.source        res_o
);

  localparam int OutW    = ppm_lh_pkg::OUT_CNT_W;
  localparam int NumBins = ppm_lh_pkg::NUM_BINS;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Result register.
  logic                       out_vld_q;
  logic                       out_stat_q;
  logic [NumBins-1:0][OutW-1:0] out_cnt_q;

  logic                            step;
  ppm_lh_pkg::ctl_t                ctl;
  logic [NumBins-1:0][BinCntW-1:0] counts;

  // The waiting byte moves on whenever the result register is free or drains.
  assign step       = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
    end
  end

  ppm_lh_hdr #(
    .MaxDim (MaxDim)
  ) u_hdr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .ctl_o  (ctl)
  );

  ppm_lh_bins #(
    .BinCntW (BinCntW)
  ) u_bins (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .ctl_i    (ctl),
    .counts_o (counts)
  );

  // A result is loaded when the processed beat finishes a file or fails the
  // header; a taken result with nothing behind it empties the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && ctl.emit) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // An error result carries zero counts.
  always_ff @(posedge clk_i) begin
    if (step && ctl.emit) begin
      out_stat_q <= ctl.err ? ppm_lh_pkg::STAT_ERR : ppm_lh_pkg::STAT_DONE;
      for (int i = 0; i < NumBins; i++) begin
        out_cnt_q[i] <= ctl.err ? '0 : OutW'(counts[i]);
      end
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.status     = out_stat_q;
  assign res_o.bin_dark   = out_cnt_q[ppm_lh_pkg::BIN_DARK];
  assign res_o.bin_low    = out_cnt_q[ppm_lh_pkg::BIN_LOW];
  assign res_o.bin_mid    = out_cnt_q[ppm_lh_pkg::BIN_MID];
  assign res_o.bin_high   = out_cnt_q[ppm_lh_pkg::BIN_HIGH];
  assign res_o.bin_bright = out_cnt_q[ppm_lh_pkg::BIN_BRIGHT];

endmodule

// File: rtl/ppm_lh_checker.sv
// ----------------------------------------------------------------------------
// ppm_lh_checker
// Port-level checks of the PPM luma histogram block, bound to its top level.
// ----------------------------------------------------------------------------
module ppm_lh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_status_i,
  input logic [31:0] bin_dark_i,
  input logic [31:0] bin_low_i,
  input logic [31:0] bin_mid_i,
  input logic [31:0] bin_high_i,
  input logic [31:0] bin_bright_i
);

  logic in_acc;
  logic res_zero;

  assign in_acc   = in_valid_i && in_ready_i;
  assign res_zero = (bin_dark_i == '0) && (bin_low_i == '0) && (bin_mid_i == '0)
                 && (bin_high_i == '0) && (bin_bright_i == '0);

  // A stalled result stays and keeps its status and its dark and bright counts.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i)
      && $stable(bin_dark_i) && $stable(bin_bright_i))
    else $error("stalled result changed");

  // A header error never reports counts.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i |-> res_zero)
    else $error("error result with non-zero counts");

  // No result is shown while reset is applied.
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  // A new result follows an accepted byte through the input and result registers.
  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(in_acc, 2))
    else $error("result without a byte two cycles earlier");

  // Bytes are never held off while the result register is empty.
  a_no_stall: assert property (@(posedge clk_i)
    !res_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind ppm_luma_histogram ppm_lh_checker u_ppm_lh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .bin_dark_i   (res_o.bin_dark),
  .bin_low_i    (res_o.bin_low),
  .bin_mid_i    (res_o.bin_mid),
  .bin_high_i   (res_o.bin_high),
  .bin_bright_i (res_o.bin_bright)
);
